FILE: rtl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
`timescale 1ns / 1ps

package ffha_pkg;

    localparam int MAX_SEGMENTS_DEF  = 64;
    localparam int HEADER_BYTES_DEF  = 16;
    localparam int PAGE_BYTES_DEF    = 4096;
    localparam int HEAP_BYTES_DEF    = 268435456;
    localparam int INITIAL_BYTES_DEF = 1048576;

    localparam logic [31:0] BASE_ADDRESS = 32'hE000_0000;
    localparam int          SPLIT_SLACK  = 16;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NULL    = 3'd1;
    localparam logic [2:0] ST_LIMIT   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    typedef struct packed {
        logic        req_type;
        logic [27:0] alloc_bytes;
        logic [31:0] free_address;
    } req_t;

    typedef struct packed {
        logic [31:0] block_address;
        logic [2:0]  status;
    } rsp_t;

    typedef struct packed {
        logic [27:0] offset;
        logic [27:0] size;
        logic        is_free;
    } seg_t;

    localparam int SEG_W = $bits(seg_t);

endpackage

FILE: rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with segment split and coalesce.
//
// Usage: a request item (allocate a byte count, or free a data address) enters
// on req_valid/req_ready; exactly one response item (block address, status)
// leaves on rsp_valid/rsp_ready. One request is worked on at a time.
// The segment table lives in one RAM with registered read data. A request
// walks the table once, one entry per cycle, pipelined over the RAM read.
// A split then moves the entries above the chosen one up a slot, and a free
// that merges moves the entries above it down, again one entry per cycle.
// After reset the block writes the initial free segment in S_INIT before
// req_ready rises. The response waits in an output register; a stalled
// receiver holds the block only when the next response is ready to leave,
// while a new request can already be accepted.
`timescale 1ns / 1ps

module first_fit_heap_allocator #(
    parameter int MAX_SEGMENTS  = ffha_pkg::MAX_SEGMENTS_DEF,
    parameter int HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF,
    parameter int PAGE_BYTES    = ffha_pkg::PAGE_BYTES_DEF,
    parameter int HEAP_BYTES    = ffha_pkg::HEAP_BYTES_DEF,
    parameter int INITIAL_BYTES = ffha_pkg::INITIAL_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ffha_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ffha_pkg::rsp_t rsp
);

    import ffha_pkg::*;

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    localparam logic [29:0] HDR     = 30'(HEADER_BYTES);
    localparam logic [30:0] PG_M1   = 31'(PAGE_BYTES - 1);
    localparam logic [31:0] HEAP_L  = 32'(HEAP_BYTES);
    localparam logic [27:0] INIT_SZ = 28'(INITIAL_BYTES - HEADER_BYTES);
    localparam logic [28:0] INIT_EX = 29'(INITIAL_BYTES);
    localparam logic [CW:0] MAX_C   = (CW+1)'(MAX_SEGMENTS);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_NEXT  = 4'd3;
    localparam logic [3:0] S_GROW  = 4'd4;
    localparam logic [3:0] S_SPLIT = 4'd5;
    localparam logic [3:0] S_UP    = 4'd6;
    localparam logic [3:0] S_WR_HI = 4'd7;
    localparam logic [3:0] S_WR_LO = 4'd8;
    localparam logic [3:0] S_MERGE = 4'd9;
    localparam logic [3:0] S_DOWN  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]    state_reg, state_next;
    req_t          req_reg, req_next;
    logic [28:0]   size_reg, size_next;
    logic [CW-1:0] count_reg, count_next;
    logic [28:0]   extent_reg, extent_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic          pend_vld_reg, pend_vld_next;
    logic [CW-1:0] pend_idx_reg, pend_idx_next;
    seg_t          prev_reg, prev_next;
    logic          prev_vld_reg, prev_vld_next;
    seg_t          next_reg, next_next;
    logic          next_vld_reg, next_vld_next;
    seg_t          pick_reg, pick_next;
    logic [CW-1:0] pick_idx_reg, pick_idx_next;
    seg_t          last_reg, last_next;
    logic          split_reg, split_next;
    logic          sh_act_reg, sh_act_next;
    logic [CW-1:0] sh_rd_reg, sh_rd_next;
    logic [CW-1:0] sh_end_reg, sh_end_next;
    logic [1:0]    sh_d_reg, sh_d_next;
    logic          wb_vld_reg, wb_vld_next;
    logic [CW-1:0] wb_idx_reg, wb_idx_next;
    rsp_t          res_reg, res_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    seg_t          ram_wseg;
    logic [AW-1:0] ram_raddr;
    logic [SEG_W-1:0] ram_rdata;
    seg_t          rd_seg;

    ffha_ram #(
        .WIDTH (SEG_W),
        .DEPTH (MAX_SEGMENTS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wseg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_seg    = seg_t'(ram_rdata);
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        logic          issue;
        logic          hit;
        logic [32:0]   addr_calc;
        logic [29:0]   need;
        logic [30:0]   grow;
        logic [31:0]   ext_sum;
        logic          pf;
        logic          nf;
        logic [CW:0]   p_idx;
        logic [CW:0]   start;
        logic [29:0]   sum;

        state_next    = state_reg;
        req_next      = req_reg;
        size_next     = size_reg;
        count_next    = count_reg;
        extent_next   = extent_reg;
        scan_idx_next = scan_idx_reg;
        pend_vld_next = 1'b0;
        pend_idx_next = pend_idx_reg;
        prev_next     = prev_reg;
        prev_vld_next = prev_vld_reg;
        next_next     = next_reg;
        next_vld_next = next_vld_reg;
        pick_next     = pick_reg;
        pick_idx_next = pick_idx_reg;
        last_next     = last_reg;
        split_next    = split_reg;
        sh_act_next   = sh_act_reg;
        sh_rd_next    = sh_rd_reg;
        sh_end_next   = sh_end_reg;
        sh_d_next     = sh_d_reg;
        wb_vld_next   = 1'b0;
        wb_idx_next   = wb_idx_reg;
        res_next      = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next      = rsp_reg;

        ram_we    = 1'b0;
        ram_waddr = pick_idx_reg[AW-1:0];
        ram_wseg  = pick_reg;
        ram_raddr = scan_idx_reg[AW-1:0];

        issue     = 1'b0;
        hit       = 1'b0;
        addr_calc = 33'(BASE_ADDRESS) + 33'(rd_seg.offset) + 33'(HDR);
        need      = 30'(size_reg) + HDR;
        grow      = (31'(need) + PG_M1) & ~PG_M1;
        ext_sum   = 32'(extent_reg) + 32'(grow);
        pf        = prev_vld_reg && prev_reg.is_free;
        nf        = next_vld_reg && next_reg.is_free;
        p_idx     = (CW+1)'(pick_idx_reg);
        start     = '0;
        sum       = '0;

        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wseg  = '{offset: 28'd0, size: INIT_SZ, is_free: 1'b1};
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next      = req;
                    size_next     = (29'(req.alloc_bytes) + 29'd3) & ~29'd3;
                    scan_idx_next = '0;
                    prev_vld_next = 1'b0;
                    next_vld_next = 1'b0;
                    split_next    = 1'b0;
                    if ((req.req_type == REQ_ALLOC && req.alloc_bytes == '0) ||
                        (req.req_type == REQ_FREE && req.free_address == '0))
                    begin
                        res_next   = '{block_address: 32'd0, status: ST_NULL};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                issue = (scan_idx_reg < count_reg);
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    pend_idx_next = scan_idx_reg;
                end
                pend_vld_next = issue;
                if (pend_vld_reg)
                begin
                    if (req_reg.req_type == REQ_ALLOC)
                    begin
                        hit = rd_seg.is_free && (29'(rd_seg.size) >= size_reg);
                    end
                    else
                    begin
                        hit = !rd_seg.is_free && (addr_calc == 33'(req_reg.free_address));
                    end
                    if (hit)
                    begin
                        pick_next     = rd_seg;
                        pick_idx_next = pend_idx_reg;
                        state_next    = (req_reg.req_type == REQ_ALLOC) ? S_SPLIT : S_NEXT;
                    end
                    else
                    begin
                        prev_next     = rd_seg;
                        prev_vld_next = 1'b1;
                        if (pend_idx_reg == count_reg - 1'b1)
                        begin
                            if (req_reg.req_type == REQ_ALLOC)
                            begin
                                last_next  = rd_seg;
                                state_next = S_GROW;
                            end
                            else
                            begin
                                res_next   = '{block_address: 32'd0, status: ST_UNKNOWN};
                                state_next = S_DONE;
                            end
                        end
                    end
                end
            end
            S_NEXT:
            begin
                next_next     = rd_seg;
                next_vld_next = pend_vld_reg;
                state_next    = S_MERGE;
            end
            S_GROW:
            begin
                if (ext_sum > HEAP_L)
                begin
                    res_next   = '{block_address: 32'd0, status: ST_LIMIT};
                    state_next = S_DONE;
                end
                else if (last_reg.is_free)
                begin
                    pick_next     = '{offset: last_reg.offset,
                                      size: 28'(31'(last_reg.size) + grow),
                                      is_free: 1'b1};
                    pick_idx_next = count_reg - 1'b1;
                    extent_next   = ext_sum[28:0];
                    state_next    = S_SPLIT;
                end
                else if ((CW+1)'(count_reg) >= MAX_C)
                begin
                    res_next   = '{block_address: 32'd0, status: ST_FULL};
                    state_next = S_DONE;
                end
                else
                begin
                    pick_next     = '{offset: extent_reg[27:0],
                                      size: 28'(grow - 31'(HDR)),
                                      is_free: 1'b1};
                    pick_idx_next = count_reg;
                    count_next    = count_reg + 1'b1;
                    extent_next   = ext_sum[28:0];
                    state_next    = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                if ((30'(pick_reg.size) >= need + 30'(SPLIT_SLACK)) &&
                    ((CW+1)'(count_reg) < MAX_C))
                begin
                    split_next = 1'b1;
                    sh_rd_next = count_reg - 1'b1;
                    if ((CW+1)'(count_reg) > p_idx + 1'b1)
                    begin
                        sh_act_next = 1'b1;
                        state_next  = S_UP;
                    end
                    else
                    begin
                        state_next = S_WR_HI;
                    end
                end
                else
                begin
                    state_next = S_WR_LO;
                end
            end
            S_UP:
            begin
                ram_we    = wb_vld_reg;
                ram_waddr = AW'(wb_idx_reg + 1'b1);
                ram_wseg  = rd_seg;
                ram_raddr = sh_rd_reg[AW-1:0];
                if (sh_act_reg)
                begin
                    wb_vld_next = 1'b1;
                    wb_idx_next = sh_rd_reg;
                    if ((CW+1)'(sh_rd_reg) == p_idx + 1'b1)
                    begin
                        sh_act_next = 1'b0;
                    end
                    else
                    begin
                        sh_rd_next = sh_rd_reg - 1'b1;
                    end
                end
                else
                begin
                    state_next = S_WR_HI;
                end
            end
            S_WR_HI:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(pick_idx_reg + 1'b1);
                ram_wseg   = '{offset: 28'(30'(pick_reg.offset) + HDR + 30'(size_reg)),
                               size: 28'(30'(pick_reg.size) - need),
                               is_free: 1'b1};
                count_next = count_reg + 1'b1;
                state_next = S_WR_LO;
            end
            S_WR_LO:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pick_idx_reg[AW-1:0];
                ram_wseg   = '{offset: pick_reg.offset,
                               size: split_reg ? size_reg[27:0] : pick_reg.size,
                               is_free: 1'b0};
                res_next   = '{block_address: BASE_ADDRESS + 32'(pick_reg.offset) + 32'(HDR),
                               status: ST_OK};
                state_next = S_DONE;
            end
            S_MERGE:
            begin
                ram_we = 1'b1;
                if (pf && nf)
                begin
                    sum       = 30'(prev_reg.size) + HDR + HDR + 30'(pick_reg.size)
                                + 30'(next_reg.size);
                    ram_waddr = AW'(pick_idx_reg - 1'b1);
                    ram_wseg  = '{offset: prev_reg.offset, size: sum[27:0], is_free: 1'b1};
                    sh_d_next = 2'd2;
                    start     = p_idx + 2'd2;
                end
                else if (pf)
                begin
                    sum       = 30'(prev_reg.size) + HDR + 30'(pick_reg.size);
                    ram_waddr = AW'(pick_idx_reg - 1'b1);
                    ram_wseg  = '{offset: prev_reg.offset, size: sum[27:0], is_free: 1'b1};
                    sh_d_next = 2'd1;
                    start     = p_idx + 1'b1;
                end
                else if (nf)
                begin
                    sum       = 30'(pick_reg.size) + HDR + 30'(next_reg.size);
                    ram_waddr = pick_idx_reg[AW-1:0];
                    ram_wseg  = '{offset: pick_reg.offset, size: sum[27:0], is_free: 1'b1};
                    sh_d_next = 2'd1;
                    start     = p_idx + 2'd2;
                end
                else
                begin
                    ram_waddr = pick_idx_reg[AW-1:0];
                    ram_wseg  = '{offset: pick_reg.offset, size: pick_reg.size,
                                  is_free: 1'b1};
                    sh_d_next = 2'd0;
                    start     = MAX_C;
                end
                count_next  = count_reg - CW'(sh_d_next);
                sh_end_next = count_reg - 1'b1;
                sh_rd_next  = start[CW-1:0];
                res_next    = '{block_address: 32'd0, status: ST_OK};
                if (sh_d_next != 2'd0 && start <= (CW+1)'(count_reg - 1'b1))
                begin
                    sh_act_next = 1'b1;
                    state_next  = S_DOWN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DOWN:
            begin
                ram_we    = wb_vld_reg;
                ram_waddr = AW'(wb_idx_reg - CW'(sh_d_reg));
                ram_wseg  = rd_seg;
                ram_raddr = sh_rd_reg[AW-1:0];
                if (sh_act_reg)
                begin
                    wb_vld_next = 1'b1;
                    wb_idx_next = sh_rd_reg;
                    if (sh_rd_reg == sh_end_reg)
                    begin
                        sh_act_next = 1'b0;
                    end
                    else
                    begin
                        sh_rd_next = sh_rd_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            count_reg     <= CW'(1);
            extent_reg    <= INIT_EX;
            pend_vld_reg  <= 1'b0;
            prev_vld_reg  <= 1'b0;
            next_vld_reg  <= 1'b0;
            split_reg     <= 1'b0;
            sh_act_reg    <= 1'b0;
            wb_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            extent_reg    <= extent_next;
            pend_vld_reg  <= pend_vld_next;
            prev_vld_reg  <= prev_vld_next;
            next_vld_reg  <= next_vld_next;
            split_reg     <= split_next;
            sh_act_reg    <= sh_act_next;
            wb_vld_reg    <= wb_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        size_reg     <= size_next;
        scan_idx_reg <= scan_idx_next;
        pend_idx_reg <= pend_idx_next;
        prev_reg     <= prev_next;
        next_reg     <= next_next;
        pick_reg     <= pick_next;
        pick_idx_reg <= pick_idx_next;
        last_reg     <= last_next;
        sh_rd_reg    <= sh_rd_next;
        sh_end_reg   <= sh_end_next;
        sh_d_reg     <= sh_d_next;
        wb_idx_reg   <= wb_idx_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

endmodule

FILE: rtl/ffha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ffha_chk.sv
// Port-level checker for the heap allocator and its bind to the top level.
`timescale 1ns / 1ps

module ffha_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input ffha_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input ffha_pkg::rsp_t rsp
);

    import ffha_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("Response item changed while stalled.");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status <= ST_UNKNOWN)
        else $error("Response status out of range.");

    a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.block_address == 32'd0)
        else $error("Failed request returned an address.");

    a_addr_base: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.block_address != 32'd0 |-> rsp.block_address > BASE_ADDRESS)
        else $error("Block address below the heap base.");

    a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("Request accepted while another item is in work.");

endmodule

bind first_fit_heap_allocator ffha_chk u_ffha_chk (.*);
